// ----- sv/mbd_pkg.sv -----
package mbd_pkg;

    // Button count and timestamp width of the sample and result items
    localparam int NUM_BUTTONS = 7;
    localparam int TIME_BITS   = 32;
    localparam int DEB_BITS    = 16;

    localparam logic [DEB_BITS-1:0] DEBOUNCE_RESET = DEB_BITS'(5);

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] raw_buttons;
        logic [TIME_BITS-1:0]   now_ms;
    } t_in_item;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] stable_buttons;
        logic [NUM_BUTTONS-1:0] pressed_mask;
        logic [NUM_BUTTONS-1:0] released_mask;
        logic [TIME_BITS-1:0]   held_ms;
    } t_out_item;

    // Control from the pipeline to the step logic
    typedef struct packed {
        logic                advance;
        logic [DEB_BITS-1:0] debounce_ms;
    } t_step_ctrl;

endpackage

// ----- sv/mbd_step.sv -----
module mbd_step
    import mbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_step_ctrl i_ctrl,
    input  t_in_item   i_item,
    output t_out_item  o_result
);

    logic [NUM_BUTTONS-1:0] r_last_raw;
    logic [NUM_BUTTONS-1:0] r_stable;
    logic [TIME_BITS-1:0]   r_change_time;
    logic [TIME_BITS-1:0]   r_press_start;
    logic [TIME_BITS-1:0]   r_press_finish;

    logic [NUM_BUTTONS-1:0] n_stable;
    logic [TIME_BITS-1:0]   n_change_time;
    logic [TIME_BITS-1:0]   n_press_start;
    logic [TIME_BITS-1:0]   n_press_finish;

    logic [NUM_BUTTONS-1:0] raw;
    logic [TIME_BITS-1:0]   now;
    logic [TIME_BITS-1:0]   elapsed;
    logic                   adopt;
    logic [NUM_BUTTONS-1:0] pressed;
    logic [NUM_BUTTONS-1:0] released;

    assign raw = i_item.raw_buttons;
    assign now = i_item.now_ms;

    // Restart the settle timer on any raw change
    assign n_change_time = (raw != r_last_raw) ? now : r_change_time;
    assign elapsed       = now - n_change_time;

    // Adopt the raw mask once settled and different from the stable mask
    assign adopt = (elapsed > TIME_BITS'(i_ctrl.debounce_ms)) && (raw != r_stable);

    assign pressed  = adopt ? (raw & ~r_stable) : '0;
    assign released = adopt ? (r_stable & ~raw) : '0;
    assign n_stable = adopt ? raw : r_stable;

    // Stamp the press on first button down, the finish on last button up
    assign n_press_start  = ((pressed != '0) && (r_stable == '0)) ? now : r_press_start;
    assign n_press_finish = ((released != '0) && (raw == '0)) ? now : r_press_finish;

    // Build the result item
    always_comb begin
        o_result.stable_buttons = n_stable;
        o_result.pressed_mask   = pressed;
        o_result.released_mask  = released;
        if (n_stable != '0) begin
            o_result.held_ms = now - n_press_start;
        end else begin
            o_result.held_ms = n_press_finish - n_press_start;
        end
    end

    // Commit state as the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw     <= '0;
            r_stable       <= '0;
            r_change_time  <= '0;
            r_press_start  <= '0;
            r_press_finish <= '0;
        end else if (i_ctrl.advance) begin
            r_last_raw     <= raw;
            r_stable       <= n_stable;
            r_change_time  <= n_change_time;
            r_press_start  <= n_press_start;
            r_press_finish <= n_press_finish;
        end
    end

endmodule

// ----- sv/multi_button_debouncer.sv -----
// An accepted item passes through the input register, the step logic and the
// result register. Throughput: one item per cycle while the output is not
// stalled; the result register frees as it is taken.
// Reset (synchronous, active low) clears both stage valids, the debounce
// state and press times, and sets debounce_ms to 5.
module multi_button_debouncer
    import mbd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [DEB_BITS-1:0] i_cfg_data
);

    logic                r_in_valid;
    t_in_item            r_in_item;
    logic                r_out_valid;
    t_out_item           r_out_item;
    logic [DEB_BITS-1:0] r_debounce;

    logic                advance;
    t_step_ctrl          step_ctrl;
    t_out_item           step_result;

    // Move the held item forward when the result register is free or drains
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    assign step_ctrl.advance     = advance;
    assign step_ctrl.debounce_ms = r_debounce;

    mbd_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (step_ctrl),
        .i_item   (r_in_item),
        .o_result (step_result)
    );

    // Hold the configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
        end else if (i_cfg_valid) begin
            r_debounce <= i_cfg_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    // An empty input stage always takes an item
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_in_ready)
        else $error("input stage empty but not ready");

    // A stalled result blocks the held item
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !advance)
        else $error("result overwritten while stalled");

    // Press and release events never share a bit
    a_events_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.pressed_mask & o_out_data.released_mask) == '0))
        else $error("pressed and released overlap");

    // Pressed bits are in the stable mask, released bits are not
    a_events_match_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (((o_out_data.pressed_mask & ~o_out_data.stable_buttons) == '0) &&
             ((o_out_data.released_mask & o_out_data.stable_buttons) == '0)))
        else $error("event mask disagrees with stable mask");

endmodule
